@@ design/complex_magnitude_gain_calibrate_defines.svh @@
// assertion macros for the port-level checker
`ifndef COMPLEX_MAGNITUDE_GAIN_CALIBRATE_DEFINES_SVH
`define COMPLEX_MAGNITUDE_GAIN_CALIBRATE_DEFINES_SVH

// next-cycle implication, disabled while reset is low
`define CMGC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("cmgc: next-cycle check failed");

// next-cycle implication that also runs during reset
`define CMGC_ASSERT_ALWAYS(label, pre, post) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("cmgc: reset check failed");

`endif

@@ design/cmgc_pkg.sv @@
// shared types and constants for the calibrated complex magnitude block
package cmgc_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned SQ_W      = 2 * DATA_W;
    localparam int unsigned GAIN_W    = 16;
    localparam int unsigned PROD_W    = DATA_W + GAIN_W;
    localparam int unsigned Q15_SHIFT = 15;
    localparam int unsigned STEPS     = DATA_W;
    localparam int unsigned CNT_W     = $clog2(STEPS);

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32767;
    localparam logic [DATA_W-1:0] MAG_MAX    = 32'hFFFF_FFFF;

    // control from the sequencer to a serial unit
    typedef struct packed {
        logic load;
        logic step;
    } t_unit_ctl;

endpackage

@@ design/cmgc_ifs.sv @@
// valid/ready channel interfaces for input and result words
interface cmgc_in_if;
    import cmgc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] real_part;
    logic signed [DATA_W-1:0] imag_part;
    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface cmgc_out_if;
    import cmgc_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] magnitude;
    modport source (output valid, output magnitude, input ready);
    modport sink   (input valid, input magnitude, output ready);
endinterface

@@ design/cmgc_sqr.sv @@
// bit-serial shift-add squarer, one multiplier bit per cycle while step is high
module cmgc_sqr (
    input  logic                            i_clk,
    input  cmgc_pkg::t_unit_ctl             i_ctl,
    input  logic [cmgc_pkg::DATA_W-1:0]     i_operand,
    output logic [cmgc_pkg::SQ_W-1:0]       o_square
);
    import cmgc_pkg::*;

    logic [DATA_W-1:0] r_mcand;
    logic [SQ_W-1:0]   r_prod;
    logic [DATA_W:0]   partial;
    logic [SQ_W-1:0]   n_prod;

    // upper half accumulates, lower half holds the remaining multiplier bits
    always_comb begin
        partial = {1'b0, r_prod[SQ_W-1:DATA_W]}
                + (r_prod[0] ? {1'b0, r_mcand} : {(DATA_W+1){1'b0}});
        n_prod  = {partial, r_prod[DATA_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_operand;
            r_prod  <= {{DATA_W{1'b0}}, i_operand};
        end else if (i_ctl.step) begin
            r_prod  <= n_prod;
        end
    end

    assign o_square = r_prod;

endmodule

@@ design/cmgc_isqrt.sv @@
// restoring square root, one root bit (two radicand bits) per cycle while step is high
module cmgc_isqrt (
    input  logic                            i_clk,
    input  cmgc_pkg::t_unit_ctl             i_ctl,
    input  logic [cmgc_pkg::SQ_W-1:0]       i_radicand,
    output logic [cmgc_pkg::DATA_W-1:0]     o_root
);
    import cmgc_pkg::*;

    logic [SQ_W-1:0]   r_rad;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_root;

    logic [DATA_W+2:0] rem_sh;
    logic [DATA_W+2:0] trial;
    logic [DATA_W+2:0] diff;
    logic              fits;

    always_comb begin
        rem_sh = {r_rem, r_rad[SQ_W-1:SQ_W-2]};
        trial  = {1'b0, r_root, 2'b01};
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.step) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= fits ? diff[DATA_W:0] : rem_sh[DATA_W:0];
            r_root <= {r_root[DATA_W-2:0], fits};
        end
    end

    assign o_root = r_root;

endmodule

@@ design/complex_magnitude_gain_calibrate.sv @@
// calibrated complex magnitude: sum of squares, serial root, q15 gain, saturate
//
// input channel i_in carries one complex word (signed 32-bit real_part and
// imag_part); output channel o_out carries one unsigned 32-bit magnitude word
// per input word, in order. both use valid/ready; a word moves at a rising
// edge where valid and ready are both high.
// the gain register (q15, 32767 is about unity) is written through
// i_cfg_we / i_cfg_wdata and resets to 32767; the user must write it only
// while the block is idle, which the block itself does not enforce.
// one word at a time: bit-serial squaring (both parts in parallel), a sum
// step that hands the 64-bit sum to the root, the restoring root (one root
// bit per cycle), the gain multiply, then the load of the output register.
// the result word shows on o_out and i_in.ready returns in the same cycle,
// so a new word is taken only once the previous one is loaded.
// a finished word sits in the output register; a stalled receiver holds
// it there while the block already accepts and works on the next word,
// which then waits in the load step until the register frees up.
// synchronous active-low reset empties the output, returns to idle and
// restores the gain.
module complex_magnitude_gain_calibrate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cmgc_in_if.sink                        i_in,
    cmgc_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [cmgc_pkg::GAIN_W-1:0]    i_cfg_wdata
);
    import cmgc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_SCALE,
        S_LOAD
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [GAIN_W-1:0]  r_gain;
    logic [PROD_W-1:0]  r_scaled;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_mag;

    logic               in_accept;
    logic [DATA_W-1:0]  re_abs;
    logic [DATA_W-1:0]  im_abs;
    logic [SQ_W-1:0]    sq_re;
    logic [SQ_W-1:0]    sq_im;
    logic [SQ_W-1:0]    sum_sq;
    logic [DATA_W-1:0]  root;
    logic [DATA_W-1:0]  sat_mag;
    logic               last_step;
    t_unit_ctl          sqr_ctl;
    t_unit_ctl          root_ctl;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;
    assign last_step  = (r_cnt == CNT_W'(STEPS - 1));

    // magnitude of each part; the most negative value maps to 2^31
    assign re_abs = i_in.real_part[DATA_W-1] ? DATA_W'(-i_in.real_part)
                                             : DATA_W'(i_in.real_part);
    assign im_abs = i_in.imag_part[DATA_W-1] ? DATA_W'(-i_in.imag_part)
                                             : DATA_W'(i_in.imag_part);

    assign sqr_ctl.load  = in_accept;
    assign sqr_ctl.step  = (r_state == S_SQUARE);
    assign root_ctl.load = (r_state == S_SUM);
    assign root_ctl.step = (r_state == S_ROOT);

    cmgc_sqr u_sqr_re (
        .i_clk     (i_clk),
        .i_ctl     (sqr_ctl),
        .i_operand (re_abs),
        .o_square  (sq_re)
    );

    cmgc_sqr u_sqr_im (
        .i_clk     (i_clk),
        .i_ctl     (sqr_ctl),
        .i_operand (im_abs),
        .o_square  (sq_im)
    );

    // each square is at most 2^62, so the sum fits in 64 bits
    assign sum_sq = sq_re + sq_im;

    cmgc_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_ctl      (root_ctl),
        .i_radicand (sum_sq),
        .o_root     (root)
    );

    // drop the q15 fraction, clamp anything above 32 bits to all ones
    assign sat_mag = r_scaled[PROD_W-1] ? MAG_MAX
                                        : r_scaled[PROD_W-2:Q15_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the load step drives the valid flag itself
            if (r_out_valid && o_out.ready && (r_state != S_LOAD)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_accept) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_cnt   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_scaled <= {{GAIN_W{1'b0}}, root} * {{DATA_W{1'b0}}, r_gain};
                    r_state  <= S_LOAD;
                end
                S_LOAD: begin
                    // wait here while the previous word is still unclaimed
                    if (!r_out_valid || o_out.ready) begin
                        r_mag       <= sat_mag;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.magnitude = r_mag;

endmodule

@@ design/cmgc_checker.sv @@
// port-level checks on the calibrated complex magnitude block
module cmgc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cmgc_pkg::DATA_W-1:0]    i_magnitude
);
    import cmgc_pkg::*;

`include "complex_magnitude_gain_calibrate_defines.svh"

    // reset empties the output register
    `CMGC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n, !i_out_valid)

    // one word at a time: taking a word makes the input side busy
    `CMGC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // a taken word keeps the input side busy past the point checked by a_busy_after_accept
    `CMGC_ASSERT_NEXT(a_busy_two_cycles, $past(i_in_valid && i_in_ready), !i_in_ready)

    // a stalled result word holds
    `CMGC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_magnitude))

endmodule

bind complex_magnitude_gain_calibrate cmgc_checker u_cmgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_magnitude (o_out.magnitude)
);

@@ tb/sv/magnitude_checker.sv @@
// checker: predicts every calibrated magnitude word and compares it with the block output
module magnitude_checker
    import cmgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cmgc_in_if                i_in_mon,
    cmgc_out_if               i_out_mon,
    input  logic              i_cfg_we,
    input  logic [GAIN_W-1:0] i_cfg_wdata,
    output int                o_pending,
    output int                o_errors,
    output int                o_checked
);

    typedef struct {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [GAIN_W-1:0]        gain;
        logic [DATA_W-1:0]        magnitude;
    } t_mag_expect;

    t_mag_expect       mag_q[$];
    logic [GAIN_W-1:0] gain_q15;
    int                error_count;
    int                checked_count;

    // floor root found one bit at a time from the top, then q15 scale and clamp
    function automatic logic [DATA_W-1:0] calibrated_magnitude(
        input logic signed [DATA_W-1:0] re,
        input logic signed [DATA_W-1:0] im,
        input logic [GAIN_W-1:0]        gain
    );
        longint          re_wide;
        longint          im_wide;
        logic [SQ_W-1:0] power;
        logic [SQ_W-1:0] root;
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] scaled;
        int              b;
        re_wide = re;
        im_wide = im;
        if (re_wide < 0) re_wide = -re_wide;
        if (im_wide < 0) im_wide = -im_wide;
        power = SQ_W'(re_wide) * SQ_W'(re_wide) + SQ_W'(im_wide) * SQ_W'(im_wide);
        root  = '0;
        for (b = DATA_W - 1; b >= 0; b--) begin
            trial = root | (SQ_W'(1) << b);
            if (trial * trial <= power) root = trial;
        end
        scaled = (root * SQ_W'(gain)) >> Q15_SHIFT;
        return (scaled > SQ_W'(MAG_MAX)) ? MAG_MAX : scaled[DATA_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_mag_expect want;
        if (!i_rst_n) begin
            gain_q15 = GAIN_RESET;
            mag_q.delete();
        end else begin
            // retire before predicting so a word cannot meet its own expectation
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (mag_q.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected magnitude word: expected none, actual %h",
                             $time, i_out_mon.magnitude);
                end else begin
                    want = mag_q.pop_front();
                    checked_count++;
                    if (i_out_mon.magnitude !== want.magnitude) begin
                        error_count++;
                        $display("%0t magnitude mismatch: expected %h, actual %h (re %0d im %0d gain %0d)",
                                 $time, want.magnitude, i_out_mon.magnitude,
                                 want.re, want.im, want.gain);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                want.re        = i_in_mon.real_part;
                want.im        = i_in_mon.imag_part;
                want.gain      = gain_q15;
                want.magnitude = calibrated_magnitude(want.re, want.im, gain_q15);
                mag_q.push_back(want);
            end
            if (i_cfg_we) gain_q15 = i_cfg_wdata;
        end
        o_pending <= mag_q.size();
        o_errors  <= error_count;
        o_checked <= checked_count;
    end

endmodule

@@ tb/sv/tb_complex_magnitude_gain_calibrate.sv @@
// testbench top: drives complex words and gain writes, checker alongside, gives the verdict
module tb_complex_magnitude_gain_calibrate;
    import cmgc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 600;   // long enough to back the block up into its input
    localparam int TAIL_CYCLES  = 100;   // quiet time after the last result has drained
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 85;

    localparam logic signed [DATA_W-1:0] P_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] P_MIN = 32'sh8000_0000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [GAIN_W-1:0] i_cfg_wdata;

    cmgc_in_if  in_ch ();
    cmgc_out_if out_ch ();

    // pacing knobs; the receiver process reads the stall rate and hold requests
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_reqs;

    int results_pending;
    int fail_count;
    int checked_words;
    int words_sent;
    int gain_writes;
    int cycle_count;

    complex_magnitude_gain_calibrate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    magnitude_checker mag_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (results_pending),
        .o_errors    (fail_count),
        .o_checked   (checked_words)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver side: random stalls, plus a long hold-off whenever the stimulus asks for one
    initial begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // one part value: half full random, the rest small values, extremes and single bits
    function automatic logic signed [DATA_W-1:0] random_part();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            5: return $urandom_range(0, 511) - 256;
            6: begin
                case ($urandom_range(0, 4))
                    0: return P_MIN;
                    1: return P_MAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            7: return P_MIN + $urandom_range(0, 15);
            8: return P_MAX - $urandom_range(0, 15);
            9: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // offer one word; valid stays up afterwards so back-to-back words need no gap
    task automatic send_word(input logic signed [DATA_W-1:0] re,
                             input logic signed [DATA_W-1:0] im);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.real_part <= re;
        in_ch.imag_part <= im;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // drop valid and wait for every outstanding magnitude word
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);   // lets the last accepted word show up in the pending count
        while (results_pending != 0) @(posedge i_clk);
    endtask

    // gain only changes with the block empty
    task automatic load_gain(input logic [GAIN_W-1:0] gain);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= gain;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gain_writes++;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                tx_idle_pct   = 87;
                rx_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                tx_idle_pct   = 0;
                rx_stall_pct <= 87;
            end
            IDLE_BOTH: begin
                tx_idle_pct   = 26;
                rx_stall_pct <= 26;
            end
            default: begin
                tx_idle_pct   = 0;
                rx_stall_pct <= 0;
            end
        endcase
    endtask

    initial begin
        int                phase;
        int                n;
        int                k;
        logic [GAIN_W-1:0] next_gain;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        in_ch.valid     = 1'b0;
        in_ch.real_part = '0;
        in_ch.imag_part = '0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        hold_reqs       = 0;
        words_sent      = 0;
        gain_writes     = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset gain, near unity
        send_word(0, 0);                 // zero input gives zero magnitude
        send_word(P_MAX, P_MAX);
        send_word(P_MIN, P_MIN);         // both parts most negative, sum is 2^63
        send_word(P_MIN, 0);             // single most negative part squares to 2^62
        send_word(0, P_MIN);
        send_word(P_MAX, P_MIN);
        send_word(-1, -1);
        send_word(1, 0);
        send_word(0, -1);
        send_word(3, -4);                // exact root
        send_word(-30000, 40000);
        send_word(P_MIN, P_MAX);

        // full-scale gain pushes the largest root into saturation
        load_gain(16'hFFFF);
        send_word(P_MIN, P_MIN);
        send_word(P_MAX, 0);
        send_word(3, 4);

        // zero gain wipes everything out
        load_gain(16'd0);
        send_word(P_MIN, P_MIN);
        send_word(5, 12);

        // exact unity, the product just fits
        load_gain(16'd32768);
        send_word(P_MAX, P_MAX);
        send_word(-8, 6);

        // random phases: each sets a gain and an idling mix
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: next_gain = GAIN_RESET;
                1: next_gain = 16'd0;
                2: next_gain = 16'hFFFF;
                3: next_gain = 16'd32768;
                4: next_gain = 16'd1;
                7: next_gain = 16'd40000;
                default: next_gain = GAIN_W'($urandom_range(0, 65535));
            endcase
            load_gain(next_gain);
            set_idling(t_idle_mode'(phase % 4));

            // receiver goes quiet while words keep coming, backing up into the input
            if (phase == 4) hold_reqs <= hold_reqs + 1;

            for (n = 0; n < PHASE_WORDS; n++) begin
                if (phase == 1 && n == 40) drain_results();
                if ($urandom_range(0, 15) == 0) begin
                    // 3-4-5 pair, the root lands exactly on 5k
                    k = $urandom_range(0, 32'h0FFF_FFFF);
                    send_word($urandom_range(0, 1) ? 3 * k : -3 * k,
                              $urandom_range(0, 1) ? 4 * k : -4 * k);
                end else begin
                    send_word(random_part(), random_part());
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d complex words, %0d magnitudes checked, over %0d gain writes",
                 words_sent, checked_words, gain_writes);
        $display("mix of idle and stall rates, one long receiver hold-off, zero and full gain");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
